@@ rtl/samdu_pkg.sv @@
package samdu_pkg;

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_MUL = 3'd2,
		ACT_DIV = 3'd3,
		ACT_REM = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

endpackage

@@ rtl/samdu_if.sv @@
interface samdu_req_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic [2:0]          action;
	logic signed [W-1:0] operand_a;
	logic signed [W-1:0] operand_b;

	modport source (output valid, action, operand_a, operand_b, input ready);
	modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface samdu_rsp_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] result;

	modport source (output valid, result, input ready);
	modport sink   (input valid, result, output ready);
endinterface

@@ rtl/signed_add_mul_div_unit_top.sv @@
// Add, subtract and undefined codes: go from idle straight to the finish step, which registers the result.
// Multiply, divide and remainder: a run state first, with one operand bit retired per
// cycle by the shift-add multiplier and the restoring divider, then the finish step.
// One transaction at a time: a new one is taken only in idle, after the finish step
// of the last one; an unread result stalls the next finish step.
// Reset (arst_n low, asynchronous) returns to idle and drops any pending result.
module signed_add_mul_div_unit_top
	import samdu_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	samdu_req_if.sink   req,
	samdu_rsp_if.source rsp
);

	localparam int CntW = $clog2(DATA_WIDTH);

	state_t                  state_q;
	state_t                  state_nxt;
	action_t                 op_q;
	logic [CntW-1:0]         cnt_q;
	logic [DATA_WIDTH-1:0]   acc_q;
	logic [DATA_WIDTH-1:0]   x_q;
	logic [DATA_WIDTH-1:0]   y_q;
	logic                    neg_q;
	logic [DATA_WIDTH-1:0]   result_q;
	logic                    out_valid_q;

	logic                    req_fire;
	logic                    out_load;
	logic [DATA_WIDTH-1:0]   a_u;
	logic [DATA_WIDTH-1:0]   b_u;
	logic [DATA_WIDTH-1:0]   mag_a;
	logic [DATA_WIDTH-1:0]   mag_b;
	logic                    neg_a;
	logic                    neg_b;
	action_t                 act_in;
	logic [DATA_WIDTH:0]     trial;
	logic [DATA_WIDTH-1:0]   diff;
	logic                    fits;
	logic [DATA_WIDTH-1:0]   res_sel;

	assign a_u    = DATA_WIDTH'(req.operand_a);
	assign b_u    = DATA_WIDTH'(req.operand_b);
	assign neg_a  = a_u[DATA_WIDTH-1];
	assign neg_b  = b_u[DATA_WIDTH-1];
	assign mag_a  = neg_a ? DATA_WIDTH'(0) - a_u : a_u;
	assign mag_b  = neg_b ? DATA_WIDTH'(0) - b_u : b_u;
	assign act_in = action_t'(req.action);

	assign req_fire = req.valid && req.ready;
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);

	// One restoring step: bring down the next dividend bit and try the divisor.
	// When the divisor fits, the difference is below the divisor and needs no top bit.
	assign trial = {acc_q, x_q[DATA_WIDTH-1]};
	assign fits  = trial >= {1'b0, y_q};
	assign diff  = trial[DATA_WIDTH-1:0] - y_q;

	assign res_sel = (op_q == ACT_DIV) ? x_q : acc_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (act_in == ACT_MUL || act_in == ACT_DIV || act_in == ACT_REM) begin
						state_nxt = ST_RUN;
					end else begin
						state_nxt = ST_FINISH;
					end
				end
			end
			ST_RUN: begin
				if (cnt_q == '0) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready  = (state_q == ST_IDLE);
		rsp.valid  = out_valid_q;
		rsp.result = result_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (req_fire) begin
				cnt_q <= CntW'(DATA_WIDTH - 1);
			end else if (state_q == ST_RUN) begin
				cnt_q <= cnt_q - CntW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q <= act_in;
			x_q  <= mag_a;
			y_q  <= mag_b;
			unique case (act_in)
				ACT_ADD: begin
					acc_q <= a_u + b_u;
					neg_q <= 1'b0;
				end
				ACT_SUB: begin
					acc_q <= a_u - b_u;
					neg_q <= 1'b0;
				end
				ACT_MUL, ACT_DIV: begin
					acc_q <= '0;
					neg_q <= neg_a ^ neg_b;
				end
				ACT_REM: begin
					acc_q <= '0;
					neg_q <= neg_a;
				end
				default: begin
					acc_q <= '0;
					neg_q <= 1'b0;
				end
			endcase
		end else if (state_q == ST_RUN) begin
			if (op_q == ACT_MUL) begin
				// Shift-add: the multiplicand moves up as the multiplier drains.
				if (y_q[0]) begin
					acc_q <= acc_q + x_q;
				end
				x_q <= {x_q[DATA_WIDTH-2:0], 1'b0};
				y_q <= {1'b0, y_q[DATA_WIDTH-1:1]};
			end else begin
				acc_q <= fits ? diff : trial[DATA_WIDTH-1:0];
				x_q   <= {x_q[DATA_WIDTH-2:0], fits};
			end
		end
		if (out_load) begin
			result_q <= neg_q ? DATA_WIDTH'(0) - res_sel : res_sel;
		end
	end

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (act_in == ACT_MUL || act_in == ACT_DIV || act_in == ACT_REM)
		|=> state_q == ST_RUN && cnt_q == CntW'(DATA_WIDTH - 1))
		else $error("long operation did not start its bit loop");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && cnt_q == '0 |=> state_q == ST_FINISH)
		else $error("bit loop did not end after its last step");

	a_add_val: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && act_in == ACT_ADD
		|=> state_q == ST_FINISH && acc_q == $past(a_u + b_u))
		else $error("sum not captured on accept");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == ST_IDLE)
		else $error("finished result not presented");

endmodule

@@ bench/tb_signed_add_mul_div_unit_top.sv @@
`timescale 1ns / 100ps

module tb_signed_add_mul_div_unit_top;
	import samdu_pkg::*;

	localparam int W = 32;
	localparam int CLK_PERIOD = 10;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 2 * W + 8;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	// Codes the block does not define; they must produce a zero result.
	localparam logic [2:0] ACT_RSVD_5 = 3'd5;
	localparam logic [2:0] ACT_RSVD_6 = 3'd6;
	localparam logic [2:0] ACT_RSVD_7 = 3'd7;

	localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};

	logic clk;
	logic arst_n;

	samdu_req_if #(.W(W)) req_ch ();
	samdu_rsp_if #(.W(W)) rsp_ch ();

	signed_add_mul_div_unit_top #(
		.DATA_WIDTH(W)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	logic [W-1:0] pending_results[$];
	int unsigned  mismatch_count;
	int unsigned  cycle_count;
	int unsigned  send_idle_pct;
	int unsigned  rcv_idle_pct;
	logic         rsp_hold;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Expected result of one operation, wrapped to W bits.
	function automatic logic [W-1:0] alu_result(logic [2:0] act, logic [W-1:0] a,
			logic [W-1:0] b);
		logic         neg_a;
		logic         neg_b;
		logic [W-1:0] mag_a;
		logic [W-1:0] mag_b;
		logic [W-1:0] prod;
		logic [W-1:0] quo;
		logic [W-1:0] rem;
		neg_a = a[W-1];
		neg_b = b[W-1];
		mag_a = neg_a ? -a : a;
		mag_b = neg_b ? -b : b;
		prod = mag_a * mag_b;
		// A restoring divider with a zero divisor sets every quotient bit
		// and leaves the dividend in the remainder.
		if (mag_b == '0) begin
			quo = '1;
			rem = mag_a;
		end else begin
			quo = mag_a / mag_b;
			rem = mag_a % mag_b;
		end
		case (act)
			ACT_ADD: return a + b;
			ACT_SUB: return a - b;
			ACT_MUL: return (neg_a != neg_b) ? -prod : prod;
			ACT_DIV: return (neg_a != neg_b) ? -quo : quo;
			ACT_REM: return neg_a ? -rem : rem;
			default: return '0;
		endcase
	endfunction

	function automatic logic [W-1:0] rand_operand();
		logic [W-1:0] v;
		case ($urandom_range(11))
			0: v = MOST_NEG;
			1: v = MOST_POS;
			2: v = '0;
			3: v = 1;
			4: v = MINUS_ONE;
			5, 6: begin
				v = $urandom_range(20);
				if ($urandom_range(1)) v = -v;
			end
			7, 8: begin
				v = $urandom >> $urandom_range(W - 1);
				if ($urandom_range(1)) v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [2:0] rand_action();
		if ($urandom_range(99) < 5) return 3'($urandom_range(ACT_RSVD_7, ACT_RSVD_5));
		return 3'($urandom_range(ACT_REM, ACT_ADD));
	endfunction

	// Offers one transaction and returns at the edge where it is taken.
	// valid is left high so that a following call can keep the bus busy.
	task automatic send_op(input logic [2:0] act, input logic [W-1:0] a,
			input logic [W-1:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid     <= 1'b1;
		req_ch.action    <= act;
		req_ch.operand_a <= a;
		req_ch.operand_b <= b;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(alu_result(act, a, b));
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_add_sub();
		send_op(ACT_ADD, MOST_POS, 1);
		send_op(ACT_ADD, MOST_NEG, MOST_NEG);
		send_op(ACT_ADD, MINUS_ONE, 1);
		send_op(ACT_SUB, MOST_NEG, 1);
		send_op(ACT_SUB, '0, MOST_NEG);
		send_op(ACT_SUB, MOST_POS, MINUS_ONE);
		drain_results();
	endtask

	task automatic test_multiply();
		send_op(ACT_MUL, MOST_NEG, MINUS_ONE);
		send_op(ACT_MUL, MOST_POS, MOST_POS);
		send_op(ACT_MUL, MINUS_ONE, MOST_NEG);
		send_op(ACT_MUL, -12345, 6789);
		drain_results();
	endtask

	task automatic test_divide();
		send_op(ACT_DIV, MOST_NEG, MINUS_ONE);
		send_op(ACT_DIV, 1000, '0);
		send_op(ACT_DIV, -1000, '0);
		send_op(ACT_DIV, 7, -2);
		send_op(ACT_DIV, MOST_NEG, MOST_POS);
		drain_results();
	endtask

	task automatic test_remainder();
		send_op(ACT_REM, MOST_NEG, MINUS_ONE);
		send_op(ACT_REM, -77, '0);
		send_op(ACT_REM, -7, 2);
		send_op(ACT_REM, MOST_POS, MOST_NEG);
		drain_results();
	endtask

	task automatic test_undefined_codes();
		send_op(ACT_RSVD_5, MOST_POS, MOST_NEG);
		send_op(ACT_RSVD_6, MINUS_ONE, MINUS_ONE);
		send_op(ACT_RSVD_7, 12345, -1);
		drain_results();
	endtask

	task automatic test_random(input int unsigned count);
		repeat (count) send_op(rand_action(), rand_operand(), rand_operand());
		drain_results();
	endtask

	// The receiver is held off for a long stretch while transactions keep
	// coming, so the unit fills up and has to stall its input.
	task automatic test_backpressure();
		fork
			begin
				rsp_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_hold <= 1'b0;
			end
		join_none
		repeat (24) send_op(rand_action(), rand_operand(), rand_operand());
		drain_results();
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin : check_results
		logic [W-1:0] want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result %h with no transaction pending",
						rsp_ch.result);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.result !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("result mismatch: expected %h, got %h", want,
							rsp_ch.result);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("signed_add_mul_div_unit_top verification failed");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		rsp_hold         = 1'b0;
		mismatch_count   = 0;
		cycle_count      = 0;
		send_idle_pct    = 11;
		rcv_idle_pct     = 52;
		req_ch.valid     = 1'b0;
		req_ch.action    = ACT_ADD;
		req_ch.operand_a = '0;
		req_ch.operand_b = '0;
		rsp_ch.ready     = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_add_sub();
		test_multiply();
		test_divide();
		test_remainder();
		test_undefined_codes();

		test_random(430);
		test_backpressure();
		send_idle_pct = 52;
		rcv_idle_pct  = 11;
		test_random(430);
		send_idle_pct = 0;
		rcv_idle_pct  = 0;
		test_random(430);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("signed_add_mul_div_unit_top verification clean");
		end else begin
			$display("signed_add_mul_div_unit_top verification failed");
		end
		$finish;
	end

endmodule
